// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the rtl top
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds on a cycle implies b on the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// a holds on a cycle implies b on the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/grc_pkg.sv =====
// types, constants and the button remap for the gamepad report conditioner
// no dependencies
package grc_pkg;

  localparam int unsigned BtnW   = 14;
  localparam int unsigned AxisW  = 16;
  localparam int unsigned DzW    = 15;
  localparam logic [DzW-1:0] DzReset = 15'd6554;
  localparam logic [14:0] MagMax = 15'd32767;

  localparam logic [1:0] LinkNone = 2'd0;
  localparam logic [1:0] LinkUp   = 2'd1;
  localparam logic [1:0] LinkDown = 2'd2;

  localparam logic ActReport = 1'b0;
  localparam logic ActClear  = 1'b1;

  typedef logic [3:0] src_bit_t;
  localparam src_bit_t BtnSrc [BtnW] = '{
    4'd4, 4'd5, 4'd12, 4'd13, 4'd14, 4'd15, 4'd2,
    4'd3, 4'd0, 4'd1, 4'd8, 4'd9, 4'd6, 4'd7
  };

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_ROOT, ST_SCALE, ST_DEN, ST_PROD, ST_DIV, ST_DONE
  } stick_state_e;

  typedef enum logic [1:0] {
    T_IDLE, T_STICK_L, T_STICK_R, T_EMIT
  } top_state_e;

  typedef struct packed {
    logic                    done;
    logic [AxisW-1:0]        x;
    logic [AxisW-1:0]        y;
  } stick_res_t;

  function automatic logic [BtnW-1:0] remap_buttons(input logic [15:0] raw);
    logic [BtnW-1:0] held;
    held = '0;
    for (int i = 0; i < BtnW; i++) begin
      held[i] = raw[BtnSrc[i]];
    end
    return held;
  endfunction

endpackage

// ===== rtl/core/grc_sqrt.sv =====
// iterative integer square root, two radicand bits per cycle
// depends on nothing but the clock and reset
module grc_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] n_q;
  logic [34:0] rem_q, shifted, trial;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q, ge;

  assign shifted = {rem_q[32:0], n_q[63:62]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = shifted >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        n_q    <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= 5'd31;
        run_q  <= 1'b1;
      end else if (run_q) begin
        n_q    <= {n_q[61:0], 2'b00};
        rem_q  <= ge ? shifted - trial : shifted;
        root_q <= {root_q[30:0], ge};
        cnt_q  <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/grc_div.sv =====
// iterative fraction divider, 31 quotient bits, one per cycle
// dividend must be below the divisor
module grc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [30:0] quo_o
);

  logic [63:0] rem_q, div_q, sh;
  logic [30:0] quo_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q, ge;

  assign sh = {rem_q[62:0], 1'b0};
  assign ge = sh >= div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q <= {16'b0, dividend_i};
        div_q <= divisor_i;
        quo_q <= '0;
        cnt_q <= 5'd30;
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= ge ? sh - div_q : sh;
        quo_q <= {quo_q[29:0], ge};
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/core/grc_stick.sv =====
// radial dead zone sequencer for one stick, one shared 32x16 multiplier
// uses grc_pkg, grc_sqrt and grc_div
module grc_stick (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [grc_pkg::AxisW-1:0]    raw_x_i,
  input  logic [grc_pkg::AxisW-1:0]    raw_y_i,
  input  logic [grc_pkg::DzW-1:0]      dz_radius_i,
  output grc_pkg::stick_res_t          res_o
);

  grc_pkg::stick_state_e state_q, state_d;

  logic [15:0] mag_x_q, mag_y_q, mag_sel;
  logic        sgn_x_q, sgn_y_q;
  logic [14:0] dz_q;
  logic        sel_q, sel_d;
  logic [33:0] s_q, s_sum;
  logic [31:0] r_q, g_q;
  logic [47:0] t_q;
  logic [63:0] den_q;
  logic [14:0] out_x_q, out_y_q;
  logic [30:0] thr;
  logic [15:0] dz_comp;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] prod;
  logic        in_dz, p_big, load;
  logic        sqrt_go, sqrt_done, div_go, div_done;
  logic [31:0] root;
  logic [30:0] quo;
  logic [31:0] q_inc;
  logic [14:0] q_mag;

  assign mag_sel = sel_q ? mag_y_q : mag_x_q;
  assign thr     = {dz_q, 16'b0} - {16'b0, dz_q};
  assign dz_comp = 16'd32768 - {1'b0, dz_q};
  assign in_dz   = r_q < {1'b0, thr};
  assign prod    = mul_a * {32'b0, mul_b};
  assign p_big   = {16'b0, prod} >= den_q;
  assign q_inc   = ({1'b0, quo} + 32'd1) >> 1;
  assign q_mag   = (q_inc > 32'd32767) ? grc_pkg::MagMax : q_inc[14:0];
  // x^2 + y^2 while the y square is on the multiplier
  assign s_sum   = s_q + {2'b0, prod[31:0]};
  assign load    = start_i && (state_q == grc_pkg::ST_IDLE || state_q == grc_pkg::ST_DONE);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = {16'b0, mag_sel};
    mul_b = mag_sel;
    unique case (state_q)
      grc_pkg::ST_SCALE: begin
        mul_a = r_q;
        mul_b = dz_comp;
      end
      grc_pkg::ST_PROD: begin
        mul_a = g_q;
        mul_b = mag_sel;
      end
      default: begin
        mul_a = {16'b0, mag_sel};
        mul_b = mag_sel;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    unique case (state_q)
      grc_pkg::ST_IDLE: if (start_i) begin
        state_d = grc_pkg::ST_SQ;
        sel_d   = 1'b0;
      end
      grc_pkg::ST_SQ: begin
        sel_d = ~sel_q;
        if (sel_q) state_d = grc_pkg::ST_ROOT;
      end
      grc_pkg::ST_ROOT:  if (sqrt_done) state_d = grc_pkg::ST_SCALE;
      grc_pkg::ST_SCALE: state_d = in_dz ? grc_pkg::ST_DONE : grc_pkg::ST_DEN;
      grc_pkg::ST_DEN: begin
        state_d = grc_pkg::ST_PROD;
        sel_d   = 1'b0;
      end
      grc_pkg::ST_PROD: begin
        if (!p_big) begin
          state_d = grc_pkg::ST_DIV;
        end else if (sel_q) begin
          state_d = grc_pkg::ST_DONE;
        end else begin
          sel_d = 1'b1;
        end
      end
      grc_pkg::ST_DIV: if (div_done) begin
        if (sel_q) begin
          state_d = grc_pkg::ST_DONE;
        end else begin
          state_d = grc_pkg::ST_PROD;
          sel_d   = 1'b1;
        end
      end
      grc_pkg::ST_DONE: begin
        if (start_i) begin
          state_d = grc_pkg::ST_SQ;
          sel_d   = 1'b0;
        end else begin
          state_d = grc_pkg::ST_IDLE;
        end
      end
      default: state_d = grc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sqrt_go = 1'b0;
    div_go  = 1'b0;
    unique case (state_q)
      grc_pkg::ST_SQ:   sqrt_go = sel_q;
      grc_pkg::ST_PROD: div_go  = ~p_big;
      default: begin
        sqrt_go = 1'b0;
        div_go  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grc_pkg::ST_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      // |2*raw+1| is the raw value (or its complement) with a one appended
      mag_x_q <= {raw_x_i[15] ? ~raw_x_i[14:0] : raw_x_i[14:0], 1'b1};
      mag_y_q <= {raw_y_i[15] ? ~raw_y_i[14:0] : raw_y_i[14:0], 1'b1};
      sgn_x_q <= raw_x_i[15];
      sgn_y_q <= raw_y_i[15];
      dz_q    <= dz_radius_i;
      out_x_q <= '0;
      out_y_q <= '0;
    end
    unique case (state_q)
      grc_pkg::ST_SQ: s_q <= (sel_q ? s_q : 34'd0) + {2'b0, prod[31:0]};
      grc_pkg::ST_ROOT: if (sqrt_done) r_q <= root;
      grc_pkg::ST_SCALE: begin
        g_q <= r_q - {1'b0, thr};
        t_q <= prod;
      end
      grc_pkg::ST_DEN: den_q <= {t_q, 16'b0} - {16'b0, t_q};
      grc_pkg::ST_PROD: if (p_big) begin
        if (sel_q) out_y_q <= grc_pkg::MagMax;
        else       out_x_q <= grc_pkg::MagMax;
      end
      grc_pkg::ST_DIV: if (div_done) begin
        if (sel_q) out_y_q <= q_mag;
        else       out_x_q <= q_mag;
      end
      default: ;
    endcase
  end

  grc_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_go),
    .radicand_i ({s_sum, 30'b0}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  grc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (prod),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  assign res_o.done = (state_q == grc_pkg::ST_DONE);
  assign res_o.x    = sgn_x_q ? 16'd0 - {1'b0, out_x_q} : {1'b0, out_x_q};
  assign res_o.y    = sgn_y_q ? 16'd0 - {1'b0, out_y_q} : {1'b0, out_y_q};

endmodule

// ===== rtl/core/gamepad_report_conditioner.sv =====
// gamepad report conditioner: button edges, link changes, stick dead zones
// sequence: a pad report runs the left stick, then the right stick, each a root and up to two
// divides (the root alone in the dead zone), before m_tvalid; a clear or ignored item goes to emit
// throughput: one item at a time, the next beat taken the cycle after the result is registered;
// the result register waits while an earlier beat is still held on the output
// reset: asynchronous, clears all pad state and sets the dead zone radius to 6554
module gamepad_report_conditioner #(
  parameter int unsigned PAD_COUNT = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid,
  output logic          s_tready,
  // pad_index, pad_present, raw_buttons, raw left x, raw left y,
  // raw right x, raw right y, left_trigger_raw, right_trigger_raw
  input  logic [103:0]  s_tdata,
  // action
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // held_mask, press_mask, release_mask, out_left_x, out_left_y,
  // out_right_x, out_right_y, out_left_trigger, out_right_trigger, link_change
  output logic [127:0]  m_tdata,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  `include "assert_macros.svh"

  grc_pkg::top_state_e state_q, state_d;

  logic [grc_pkg::DzW-1:0]  dz_q;
  logic [grc_pkg::BtnW-1:0] last_mask_q [PAD_COUNT];
  logic [PAD_COUNT-1:0]     conn_q;

  logic [1:0]  pad;
  logic        present, accept, report, pad_ok;
  logic [15:0] raw_btn;
  logic [grc_pkg::BtnW-1:0] held, prev;
  logic        prev_conn;

  logic [13:0] held_q, press_q, rel_q;
  logic [7:0]  lt_q, rt_q;
  logic [1:0]  link_q;
  logic [15:0] rx_q, ry_q, olx_q, oly_q, orx_q, ory_q;
  logic [127:0] m_data_q;
  logic        m_valid_q;

  logic        stick_go;
  logic [15:0] stick_x, stick_y;
  grc_pkg::stick_res_t stick_res;
  logic        emit;

  assign pad      = s_tdata[1:0];
  assign present  = s_tdata[2];
  assign accept   = s_tvalid & s_tready;
  assign pad_ok   = 32'(pad) < PAD_COUNT;
  assign report   = (s_tuser == grc_pkg::ActReport) && pad_ok;
  assign raw_btn  = present ? s_tdata[18:3] : 16'd0;
  assign held     = grc_pkg::remap_buttons(raw_btn);

  always_comb begin
    prev      = '0;
    prev_conn = 1'b0;
    for (int i = 0; i < PAD_COUNT; i++) begin
      if (32'(pad) == i) begin
        prev      = last_mask_q[i];
        prev_conn = conn_q[i];
      end
    end
  end

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {17'b0, dz_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= grc_pkg::DzReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      dz_q <= pwdata[14:0];
    end
  end

  // pad state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q <= '0;
      for (int i = 0; i < PAD_COUNT; i++) last_mask_q[i] <= '0;
    end else if (accept) begin
      if (s_tuser == grc_pkg::ActClear) begin
        conn_q <= '0;
        for (int i = 0; i < PAD_COUNT; i++) last_mask_q[i] <= '0;
      end else if (pad_ok) begin
        for (int i = 0; i < PAD_COUNT; i++) begin
          if (32'(pad) == i) begin
            last_mask_q[i] <= held;
            conn_q[i]      <= present;
          end
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      grc_pkg::T_IDLE: if (accept) begin
        state_d = report ? grc_pkg::T_STICK_L : grc_pkg::T_EMIT;
      end
      grc_pkg::T_STICK_L: if (stick_res.done) state_d = grc_pkg::T_STICK_R;
      grc_pkg::T_STICK_R: if (stick_res.done) state_d = grc_pkg::T_EMIT;
      grc_pkg::T_EMIT: if (!m_valid_q || m_tready) state_d = grc_pkg::T_IDLE;
      default: state_d = grc_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    stick_go = 1'b0;
    stick_x  = rx_q;
    stick_y  = ry_q;
    emit     = 1'b0;
    unique case (state_q)
      grc_pkg::T_IDLE: begin
        s_tready = 1'b1;
        stick_go = s_tvalid && report;
        stick_x  = present ? s_tdata[34:19] : 16'd0;
        stick_y  = present ? s_tdata[50:35] : 16'd0;
      end
      grc_pkg::T_STICK_L: stick_go = stick_res.done;
      grc_pkg::T_STICK_R: ;
      grc_pkg::T_EMIT:    emit = !m_valid_q || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= grc_pkg::T_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) m_valid_q <= 1'b1;
      else if (m_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q  <= report ? held : '0;
      press_q <= report ? (held & ~prev) : '0;
      rel_q   <= report ? (prev & ~held) : '0;
      lt_q    <= (report && present) ? s_tdata[90:83] : 8'd0;
      rt_q    <= (report && present) ? s_tdata[98:91] : 8'd0;
      rx_q    <= present ? s_tdata[66:51] : 16'd0;
      ry_q    <= present ? s_tdata[82:67] : 16'd0;
      olx_q   <= '0;
      oly_q   <= '0;
      orx_q   <= '0;
      ory_q   <= '0;
      if (!report) begin
        link_q <= grc_pkg::LinkNone;
      end else if (present && !prev_conn) begin
        link_q <= grc_pkg::LinkUp;
      end else if (!present && prev_conn) begin
        link_q <= grc_pkg::LinkDown;
      end else begin
        link_q <= grc_pkg::LinkNone;
      end
    end
    if (state_q == grc_pkg::T_STICK_L && stick_res.done) begin
      olx_q <= stick_res.x;
      oly_q <= stick_res.y;
    end
    if (state_q == grc_pkg::T_STICK_R && stick_res.done) begin
      orx_q <= stick_res.x;
      ory_q <= stick_res.y;
    end
    if (emit) begin
      m_data_q <= {4'b0, link_q, rt_q, lt_q, ory_q, orx_q,
                   oly_q, olx_q, rel_q, press_q, held_q};
    end
  end

  grc_stick u_stick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (stick_go),
    .raw_x_i     (stick_x),
    .raw_y_i     (stick_y),
    .dz_radius_i (dz_q),
    .res_o       (stick_res)
  );

  assign m_tvalid = m_valid_q;
  assign m_tdata  = m_data_q;

  `ASSERT_IMPLIES(a_done_in_stick, clk_i, rst_ni, stick_res.done,
    state_q == grc_pkg::T_STICK_L || state_q == grc_pkg::T_STICK_R)
  `ASSERT_NEXT(a_clear_drops_links, clk_i, rst_ni,
    accept && s_tuser == grc_pkg::ActClear, conn_q == '0)
  `ASSERT_IMPLIES(a_link_code, clk_i, rst_ni, m_valid_q, m_data_q[123:122] != 2'd3)

endmodule

// ===== dv/tb_gamepad_report_conditioner.sv =====
// testbench for gamepad_report_conditioner: button edges, link changes, stick dead zones
// self-checking against an in-bench predictor; depends on grc_pkg and the rtl top
`timescale 1ns / 100ps

module tb_gamepad_report_conditioner;

  localparam int unsigned NumPads  = 4;
  localparam int unsigned WdogMax  = 6000;

  logic          clk_i;
  logic          rst_ni;
  logic          s_tvalid;
  logic          s_tready;
  logic [103:0]  s_tdata;   // pad_index, pad_present, raw_buttons, lx, ly, rx, ry, lt, rt
  logic          s_tuser;   // action
  logic          m_tvalid;
  logic          m_tready;
  logic [127:0]  m_tdata;   // held, press, release, olx, oly, orx, ory, olt, ort, link_change
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  gamepad_report_conditioner #(.PAD_COUNT(NumPads)) i_dut (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // result field layout in m_tdata
  localparam int FieldLo [10] = '{0, 14, 28, 42, 58, 74, 90, 106, 114, 122};
  localparam int FieldW  [10] = '{14, 14, 14, 16, 16, 16, 16, 8, 8, 2};

  logic [13:0]     prev_held [NumPads];
  logic            pad_up    [NumPads];
  logic [grc_pkg::DzW-1:0]  dz_shadow;
  logic [127:0]    pending_reports [$];
  bit              quiet;
  int              errors;
  int              wdog;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint unsigned root_u64(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] scale_axis(input int a, input longint unsigned g,
                                             input longint unsigned den);
    longint unsigned p, q, rem, mag;
    p = longint'(a < 0 ? -a : a) * g;
    if (p >= den) begin
      mag = 32767;
    end else begin
      q = 0;
      rem = p;
      for (int i = 0; i < 31; i++) begin
        rem <<= 1;
        q <<= 1;
        if (rem >= den) begin
          rem -= den;
          q |= 1;
        end
      end
      mag = (q + 1) >> 1;
      if (mag > 32767) mag = 32767;
    end
    return a < 0 ? 16'(-mag) : 16'(mag);
  endfunction

  // radial dead zone on one stick, output packed {y, x}
  function automatic logic [31:0] radial_stick(input logic [15:0] rx, input logic [15:0] ry);
    int ax, ay;
    longint unsigned sq, r, thr, g, den;
    ax = 2 * int'($signed(rx)) + 1;
    ay = 2 * int'($signed(ry)) + 1;
    sq = longint'(ax) * ax + longint'(ay) * ay;
    r = root_u64(sq << 30);
    thr = 65535 * longint'(dz_shadow);
    if (r < thr) return '0;
    g = r - thr;
    den = 65535 * r * (32768 - longint'(dz_shadow));
    return {scale_axis(ay, g, den), scale_axis(ax, g, den)};
  endfunction

  function automatic logic [127:0] predict_report(input logic act, input logic [103:0] d);
    logic [127:0] res;
    logic [1:0]   pad;
    logic         present;
    logic [15:0]  btn, lx, ly, rx, ry;
    logic [7:0]   lt, rt;
    logic [13:0]  held, prev;
    logic [31:0]  ls, rs;
    logic [1:0]   link;
    res = '0;
    if (act == grc_pkg::ActClear) begin
      for (int i = 0; i < NumPads; i++) begin
        prev_held[i] = '0;
        pad_up[i] = 1'b0;
      end
      return res;
    end
    pad = d[1:0];
    present = d[2];
    {btn, lx, ly, rx, ry, lt, rt} = '0;
    if (present) begin
      btn = d[18:3]; lx = d[34:19]; ly = d[50:35]; rx = d[66:51]; ry = d[82:67];
      lt = d[90:83]; rt = d[98:91];
    end
    held = {btn[7], btn[6], btn[9], btn[8], btn[1], btn[0], btn[3], btn[2],
            btn[15], btn[14], btn[13], btn[12], btn[5], btn[4]};
    prev = prev_held[pad];
    prev_held[pad] = held;
    ls = radial_stick(lx, ly);
    rs = radial_stick(rx, ry);
    link = grc_pkg::LinkNone;
    if (present && !pad_up[pad]) begin
      pad_up[pad] = 1'b1;
      link = grc_pkg::LinkUp;
    end else if (!present && pad_up[pad]) begin
      pad_up[pad] = 1'b0;
      link = grc_pkg::LinkDown;
    end
    res[123:0] = {link, rt, lt, rs[31:16], rs[15:0], ls[31:16], ls[15:0],
                  prev & ~held, held & ~prev, held};
    return res;
  endfunction

  task automatic send_beat(input logic act, input logic [1:0] pad, input logic present,
                           input logic [15:0] btn, input logic [15:0] lx, input logic [15:0] ly,
                           input logic [15:0] rx, input logic [15:0] ry,
                           input logic [7:0] lt, input logic [7:0] rt);
    logic [103:0] d;
    d = {5'd0, rt, lt, ry, rx, ly, lx, btn, present, pad};
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= d;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pending_reports.insert(pending_reports.size(), predict_report(act, d));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_dz_radius(input logic [grc_pkg::DzW-1:0] v);
    drain();
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= '0;
    pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dz_shadow = v;
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'($signed($urandom_range(0, 2000)) - 1000);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return 16'($signed($urandom_range(0, 20000)) - 10000);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_reports(input int n);
    logic [1:0] pad;
    for (int i = 0; i < n; i++) begin
      pad = 2'($urandom);
      if ($urandom_range(0, 59) == 0) begin
        send_beat(grc_pkg::ActClear, pad, 1'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_beat(grc_pkg::ActReport, pad, $urandom_range(0, 7) != 0, 16'($urandom),
                  rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                  8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    send_beat(grc_pkg::ActReport, 2'd0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              16'h0000, 0, 0);
    send_beat(grc_pkg::ActReport, 2'd0, 1'b1, 16'hffff, 16'h7fff, 16'h7fff, 16'h8000,
              16'h8000, 255, 255);
    send_beat(grc_pkg::ActReport, 2'd0, 1'b1, 16'h0c00, 16'h7fff, 16'h0000, 16'h0000,
              16'h8000, 1, 128);
    send_beat(grc_pkg::ActReport, 2'd0, 1'b1, 16'hf3ff, 16'hffff, 16'hffff, 16'h1000,
              16'hf000, 0, 0);
    send_beat(grc_pkg::ActReport, 2'd1, 1'b0, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff,
              16'h7fff, 9, 9);
    send_beat(grc_pkg::ActReport, 2'd1, 1'b1, 16'h5555, 16'h0c00, 16'hf400, 16'h0cd0,
              16'h0000, 7, 3);
    send_beat(grc_pkg::ActReport, 2'd1, 1'b1, 16'haaaa, 16'h0d00, 16'h0000, 16'h8001,
              16'h7fff, 3, 7);
    send_beat(grc_pkg::ActReport, 2'd1, 1'b0, 16'haaaa, 16'h1234, 16'h4321, 16'h0000,
              16'h0000, 3, 7);
    send_beat(grc_pkg::ActReport, 2'd2, 1'b1, 16'h00ff, 16'h5a82, 16'h5a82, 16'ha57e,
              16'h5a82, 200, 50);
    send_beat(grc_pkg::ActReport, 2'd3, 1'b1, 16'hff00, 16'h8000, 16'h7fff, 16'h0001,
              16'hfffe, 50, 200);
    send_beat(grc_pkg::ActClear, 2'd3, 1'b1, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff,
              16'h7fff, 255, 255);
    send_beat(grc_pkg::ActReport, 2'd3, 1'b0, 16'h0000, 0, 0, 0, 0, 0, 0);
    send_beat(grc_pkg::ActReport, 2'd2, 1'b1, 16'h00ff, 16'h0000, 16'h0000, 16'h0000,
              16'h0000, 0, 0);
  endtask

  task automatic test_dz_extremes();
    write_dz_radius('0);
    send_beat(grc_pkg::ActReport, 2'd0, 1'b0, 16'h0, 0, 0, 0, 0, 0, 0);
    send_beat(grc_pkg::ActReport, 2'd0, 1'b1, 16'h1, 16'h0000, 16'hffff, 16'h7fff,
              16'h8000, 0, 0);
    random_reports(250);
    write_dz_radius(15'h7fff);
    send_beat(grc_pkg::ActReport, 2'd1, 1'b1, 16'h2, 16'h7fff, 16'h7fff, 16'h8000,
              16'h8000, 0, 0);
    send_beat(grc_pkg::ActReport, 2'd1, 1'b1, 16'h4, 16'h7fff, 16'h0000, 16'h0000,
              16'h8000, 0, 0);
    random_reports(200);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 3; k++) begin
      write_dz_radius(grc_pkg::DzW'($urandom));
      random_reports(100);
    end
    write_dz_radius(grc_pkg::DzReset);
    random_reports(200);
  endtask

  task automatic test_steady_flow();
    quiet = 1'b1;
    write_dz_radius(15'd1000);
    random_reports(383);
  endtask

  // result checker
  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result got %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        for (int f = 0; f < 10; f++) begin
          if (((m_tdata ^ want) >> FieldLo[f]) & ((128'd1 << FieldW[f]) - 1)) begin
            $display("%0t: field %0d mismatch expected %h actual %h", $time, f,
                     (want >> FieldLo[f]) & ((128'd1 << FieldW[f]) - 1),
                     (m_tdata >> FieldLo[f]) & ((128'd1 << FieldW[f]) - 1));
            errors++;
          end
        end
      end
    end
  end

  // receiver stalls
  initial begin
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // watchdog on beats moving or apb access
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog > WdogMax) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tuser  = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    quiet    = 1'b0;
    errors   = 0;
    wdog     = 0;
    dz_shadow = grc_pkg::DzReset;
    for (int i = 0; i < NumPads; i++) begin
      prev_held[i] = '0;
      pad_up[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_dz_extremes();
    test_random_settings();
    test_steady_flow();
    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/grc_pkg.sv
rtl/core/grc_sqrt.sv
rtl/core/grc_div.sv
rtl/core/grc_stick.sv
rtl/core/gamepad_report_conditioner.sv
dv/tb_gamepad_report_conditioner.sv
